// ===== sv/svge_pkg.sv =====
// Package for the state vector gate engine: sizes, codes, state and control types,
// plus helper functions for saturation and pair addressing.
// Standalone; used by svge_alu and state_vector_gate_engine_unit.
`default_nettype none

package svge_pkg;

  localparam int QUBIT_COUNT   = 8;
  localparam int STATE_COUNT   = 1 << QUBIT_COUNT;
  localparam int ADDR_W        = QUBIT_COUNT;
  localparam int PAIR_W        = ADDR_W - 1;
  localparam int QB_W          = 3;
  localparam int AMP_WIDTH     = 16;
  localparam int UNI_W         = AMP_WIDTH - 1;
  localparam int UNIFORM_RESET = 2048;

  // 1/sqrt(2) as Q0.16
  localparam int HALF_ROOT_Q16 = 46341;
  localparam int KFRAC         = 16;
  localparam int SUM_W         = AMP_WIDTH + 1;
  localparam int PRE_W         = SUM_W + KFRAC + 1;
  localparam int Q_W           = PRE_W - KFRAC;

  typedef logic signed [AMP_WIDTH-1:0] amp_t;

  // real part in the low half
  typedef struct packed {
    amp_t im;
    amp_t re;
  } cplx_t;

  typedef enum logic [2:0] {
    MODE_LOAD    = 3'd0,
    MODE_READ    = 3'd1,
    MODE_UNIFORM = 3'd2,
    MODE_HAD     = 3'd3,
    MODE_CZ      = 3'd4,
    MODE_CHAIN   = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_SWEEP,
    ST_DRAIN,
    ST_H_RDA,
    ST_H_RDB,
    ST_H_SUM,
    ST_H_DIF,
    ST_H_WRA,
    ST_H_WRB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic neg;
    logic sub;
  } alu_ctl_t;

  // clamp a widened value to the amplitude range
  function automatic amp_t sat_q(input logic signed [Q_W-1:0] q);
    logic [Q_W-AMP_WIDTH:0] upper;
    amp_t r;
    upper = q[Q_W-1:AMP_WIDTH-1];
    if ((&upper) || (~|upper)) begin
      r = q[AMP_WIDTH-1:0];
    end else if (q[Q_W-1]) begin
      r = {1'b1, {(AMP_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(AMP_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  // lower index of a butterfly pair: pair number with a zero inserted at the target bit
  function automatic logic [ADDR_W-1:0] insert_zero(input logic [PAIR_W-1:0] p,
                                                    input logic [QB_W-1:0]   t);
    logic [ADDR_W-1:0] pw;
    logic [ADDR_W-1:0] low_mask;
    pw       = {1'b0, p};
    low_mask = (ADDR_W'(1) << t) - ADDR_W'(1);
    return ((pw & ~low_mask) << 1) | (pw & low_mask);
  endfunction

endpackage

`default_nettype wire

// ===== sv/svge_alu.sv =====
// Shared two-stage arithmetic unit of the gate engine: butterfly sum or difference
// scaled by 1/sqrt(2) with rounding, or saturating negation. Uses svge_pkg.
`default_nettype none

module svge_alu import svge_pkg::*; (
  input  wire logic     clk,
  input  wire alu_ctl_t ctl,
  input  wire cplx_t    a,
  input  wire cplx_t    b,
  output cplx_t         res
);

  localparam logic signed [SUM_W-1:0] KSCALE = SUM_W'(HALF_ROOT_Q16);
  localparam logic signed [PRE_W-1:0] ROUND  = PRE_W'(1) <<< (KFRAC - 1);

  logic signed [SUM_W-1:0] sum_re, sum_im;
  logic signed [PRE_W-1:0] pre_re_next, pre_im_next;
  logic signed [PRE_W-1:0] pre_re, pre_im;

  always_comb begin
    logic signed [SUM_W-1:0] a_re, a_im, b_re, b_im;
    a_re = {a.re[AMP_WIDTH-1], a.re};
    a_im = {a.im[AMP_WIDTH-1], a.im};
    b_re = {b.re[AMP_WIDTH-1], b.re};
    b_im = {b.im[AMP_WIDTH-1], b.im};
    if (ctl.neg) begin
      sum_re = -a_re;
      sum_im = -a_im;
    end else if (ctl.sub) begin
      sum_re = a_re - b_re;
      sum_im = a_im - b_im;
    end else begin
      sum_re = a_re + b_re;
      sum_im = a_im + b_im;
    end
  end

  // negation bypasses the multiplier by pre-shifting so stage two is shared
  always_comb begin
    if (ctl.neg) begin
      pre_re_next = PRE_W'(sum_re) <<< KFRAC;
      pre_im_next = PRE_W'(sum_im) <<< KFRAC;
    end else begin
      pre_re_next = PRE_W'(sum_re) * PRE_W'(KSCALE) + ROUND;
      pre_im_next = PRE_W'(sum_im) * PRE_W'(KSCALE) + ROUND;
    end
  end

  always_ff @(posedge clk) begin
    pre_re  <= pre_re_next;
    pre_im  <= pre_im_next;
    res.re  <= sat_q(pre_re[PRE_W-1:KFRAC]);
    res.im  <= sat_q(pre_im[PRE_W-1:KFRAC]);
  end

endmodule

`default_nettype wire

// ===== sv/state_vector_gate_engine_unit.sv =====
// Top level of the state vector gate engine: amplitude store, command sequencer,
// result register and configuration register. Uses svge_pkg and svge_alu.
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   s_tuser mode, s_tdata command fields
//  m_*       out        m_tvalid/m_tready   m_tuser is_read_data, m_tdata amplitude
//  cfg_*     in         cfg_valid/cfg_ready cfg_data uniform amplitude
//
// One command at a time; s_tready is high only while the sequencer is idle.
// Command steps: load, read, uniform init, controlled-z and chain (one pipelined
// read-negate-write sweep), hadamard (read, read, sum, difference, write, write per pair);
// the single read and single write port of the store set these sequences.
// After reset a clearing pass writes zero to all 256 entries before
// the first command is taken; configuration writes are taken at any time.
// A stalled result holds in the output register and delays only the return to idle.
`default_nettype none

module state_vector_gate_engine_unit import svge_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [2:0]  s_tuser,   // mode
  input  wire logic [47:0] s_tdata,   // index, target_qubit, control_qubit, real_in, imag_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [0:0]       m_tuser,   // is_read_data
  output logic [31:0]      m_tdata,   // real_out, imag_out
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [UNI_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [ADDR_W-1:0] cnt;
  logic [PAIR_W-1:0] pair;
  mode_t             cmd_mode;
  logic [QB_W-1:0]   cmd_tq, cmd_cq;
  logic [UNI_W-1:0]  uniform;

  cplx_t             mem [STATE_COUNT];
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  cplx_t             rd_data, wr_data;

  cplx_t             a_reg, b_reg;
  logic              a_load, b_load;
  logic [2:0]                p_wr;
  logic [2:0][ADDR_W-1:0]    p_addr;
  logic              sweep_issue, flip;

  alu_ctl_t          alu_ctl;
  cplx_t             alu_a, alu_b, alu_res;

  logic              accept, out_load, cnt_inc, pair_inc, cnt_last, pair_last;
  mode_t             in_mode;
  logic [ADDR_W-1:0] in_index;
  logic [ADDR_W-1:0] pair_lo, pair_hi;
  cplx_t             in_amp;

  assign in_mode   = mode_t'(s_tuser);
  assign in_index  = s_tdata[7:0];
  assign in_amp.re = s_tdata[29:14];
  assign in_amp.im = s_tdata[45:30];

  assign accept    = s_tvalid && s_tready;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign cfg_ready = 1'b1;
  assign cnt_last  = &cnt;
  assign pair_last = &pair;
  assign pair_lo   = insert_zero(pair, cmd_tq);
  assign pair_hi   = pair_lo | (ADDR_W'(1) << cmd_tq);

  // sign flip of the entry being read in a phase sweep
  always_comb begin
    if (cmd_mode == MODE_CHAIN) begin
      flip = ^(cnt[ADDR_W-2:0] & cnt[ADDR_W-1:1]);
    end else begin
      flip = cnt[cmd_cq] & cnt[cmd_tq];
    end
  end

  svge_alu u_alu (
    .clk (clk),
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (cnt_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (in_mode)
            MODE_LOAD:    state_next = ST_DONE;
            MODE_READ:    state_next = ST_READ;
            MODE_UNIFORM: state_next = ST_FILL;
            MODE_HAD:     state_next = ST_H_RDA;
            MODE_CZ:      state_next = ST_SWEEP;
            MODE_CHAIN:   state_next = ST_SWEEP;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_READ:  state_next = ST_DONE;
      ST_FILL:  if (cnt_last) state_next = ST_DONE;
      ST_SWEEP: if (cnt_last) state_next = ST_DRAIN;
      ST_DRAIN: if (p_wr == '0) state_next = ST_DONE;
      ST_H_RDA: state_next = ST_H_RDB;
      ST_H_RDB: state_next = ST_H_SUM;
      ST_H_SUM: state_next = ST_H_DIF;
      ST_H_DIF: state_next = ST_H_WRA;
      ST_H_WRA: state_next = ST_H_WRB;
      ST_H_WRB: state_next = pair_last ? ST_DONE : ST_H_RDA;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // datapath control
  always_comb begin
    s_tready    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cnt;
    wr_en       = 1'b0;
    wr_addr     = cnt;
    wr_data     = '0;
    cnt_inc     = 1'b0;
    pair_inc    = 1'b0;
    a_load      = 1'b0;
    b_load      = 1'b0;
    sweep_issue = 1'b0;
    alu_a       = rd_data;
    alu_b       = b_reg;
    alu_ctl     = '{neg: 1'b1, sub: 1'b0};
    if (p_wr[2]) begin
      wr_en   = 1'b1;
      wr_addr = p_addr[2];
      wr_data = alu_res;
    end
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        rd_addr  = in_index;
        wr_addr  = in_index;
        wr_data  = in_amp;
        if (s_tvalid && in_mode == MODE_READ) rd_en = 1'b1;
        if (s_tvalid && in_mode == MODE_LOAD) wr_en = 1'b1;
      end
      ST_FILL: begin
        wr_en      = 1'b1;
        wr_data.re = {1'b0, uniform};
        cnt_inc    = 1'b1;
      end
      ST_SWEEP: begin
        rd_en       = 1'b1;
        sweep_issue = 1'b1;
        cnt_inc     = 1'b1;
      end
      ST_H_RDA: begin
        rd_en   = 1'b1;
        rd_addr = pair_lo;
      end
      ST_H_RDB: begin
        rd_en   = 1'b1;
        rd_addr = pair_hi;
        a_load  = 1'b1;
      end
      ST_H_SUM: begin
        alu_a   = a_reg;
        alu_b   = rd_data;
        alu_ctl = '{neg: 1'b0, sub: 1'b0};
        b_load  = 1'b1;
      end
      ST_H_DIF: begin
        alu_a   = a_reg;
        alu_b   = b_reg;
        alu_ctl = '{neg: 1'b0, sub: 1'b1};
      end
      ST_H_WRA: begin
        wr_en   = 1'b1;
        wr_addr = pair_lo;
        wr_data = alu_res;
      end
      ST_H_WRB: begin
        wr_en    = 1'b1;
        wr_addr  = pair_hi;
        wr_data  = alu_res;
        pair_inc = 1'b1;
      end
      ST_READ, ST_DRAIN, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      pair     <= '0;
      p_wr     <= '0;
      m_tvalid <= 1'b0;
      uniform  <= UNI_W'(UNIFORM_RESET);
    end else begin
      state <= state_next;
      if (cnt_inc) cnt <= cnt + 1'b1;
      if (pair_inc) pair <= pair + 1'b1;
      p_wr <= {p_wr[1:0], sweep_issue & flip};
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) uniform <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode <= in_mode;
      cmd_tq   <= s_tdata[10:8];
      cmd_cq   <= s_tdata[13:11];
    end
    if (a_load) a_reg <= rd_data;
    if (b_load) b_reg <= rd_data;
    p_addr <= {p_addr[1:0], cnt};
    if (out_load) begin
      if (cmd_mode == MODE_READ) begin
        m_tdata <= rd_data;
      end else begin
        m_tdata <= '0;
      end
      m_tuser <= (cmd_mode == MODE_READ);
    end
  end

  // amplitude store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // a sweep write lands on the entry whose read issued it, its address carried along p_addr
  a_sweep_addr: assert property (@(posedge clk) disable iff (rst)
    p_wr[2] |-> p_addr[2] == $past(rd_addr, 3))
    else $error("sweep write address does not match its read");

  // the two halves of a butterfly differ only in the target bit
  a_pair_addr: assert property (@(posedge clk) disable iff (rst)
    state == ST_H_WRB |-> (wr_addr ^ $past(wr_addr)) == (ADDR_W'(1) << cmd_tq))
    else $error("butterfly pair addresses are not partners");

  // no sweep write is still in flight once the sequencer is idle
  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> p_wr == '0)
    else $error("sweep pipeline not drained at idle");

endmodule

`default_nettype wire
